@@ src/pmb_pkg.sv @@
// Shared types and constants of the prioritised magnitude budget block.
package pmb_pkg;

  // Number of register stages in the square root and divider pipelines.
  // Each stage resolves two result bits of a 32-bit result.
  localparam int unsigned SQRT_STAGES = 16;
  localparam int unsigned DIV_STAGES  = 16;

  // Configuration register map.
  localparam int unsigned PADDR_W           = 3;
  localparam logic        REG_MAX_MAGNITUDE = 1'b0;
  localparam logic [30:0] MAX_MAG_RESET     = 31'd65536;

  // How a source word is granted.
  typedef enum logic [1:0] {
    MODE_ZERO,
    MODE_PASS,
    MODE_SCALE
  } mode_e;

  // Word payload carried alongside the arithmetic.
  typedef struct packed {
    logic               first;
    logic               active;
    logic               inr;
    logic [9:0]         p;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
  } pl_t;

endpackage

@@ src/pmb_sqrt.sv @@
// Pipelined integer square root of a 64-bit value, two result bits per stage.
module pmb_sqrt import pmb_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] sq_i,
  output logic [31:0] root_o
);

  localparam int unsigned LAST = SQRT_STAGES - 1;

  logic [32:0] rem_q  [LAST];
  logic [63:0] n_q    [LAST];
  logic [31:0] root_q [SQRT_STAGES];

  // One restoring step: bring down a bit pair and try to subtract.
  function automatic logic [64:0] sqrt_step(input logic [32:0] rem, input logic [31:0] root,
                                            input logic [1:0] pair);
    logic [34:0] r;
    logic [34:0] t;
    logic [34:0] d;
    r = {rem, pair};
    t = {1'b0, root, 2'b01};
    d = r - t;
    if (r >= t) begin
      return {d[32:0], root[30:0], 1'b1};
    end
    return {r[32:0], root[30:0], 1'b0};
  endfunction

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_st
    logic [32:0] rem_in;
    logic [31:0] root_in;
    logic [63:0] n_in;
    logic [64:0] s1;
    logic [64:0] s2;

    if (k == 0) begin : g_head
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_in    = sq_i;
    end else begin : g_body
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign n_in    = n_q[k-1];
    end

    assign s1 = sqrt_step(rem_in, root_in, n_in[63:62]);
    assign s2 = sqrt_step(s1[64:32], s1[31:0], n_in[61:60]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k] <= s2[31:0];
      end
    end

    if (k < LAST) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= s2[64:32];
          n_q[k]   <= {n_in[59:0], 4'b0000};
        end
      end
    end
  end

  assign root_o = root_q[LAST];

endmodule

@@ src/pmb_div.sv @@
// Pipelined unsigned divider for a quotient known to fit 32 bits, two bits per stage.
module pmb_div import pmb_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic [31:0] quo_o
);

  localparam int unsigned LAST = DIV_STAGES - 1;

  logic [31:0] rem_q [LAST];
  logic [31:0] n_q   [LAST];
  logic [31:0] den_q [LAST];
  logic [31:0] quo_q [DIV_STAGES];

  // One restoring step: bring down a dividend bit and try to subtract.
  function automatic logic [32:0] div_step(input logic [31:0] rem, input logic [31:0] den,
                                           input logic b);
    logic [32:0] r;
    logic [32:0] d;
    r = {rem, b};
    d = r - {1'b0, den};
    if (r >= {1'b0, den}) begin
      return {d[31:0], 1'b1};
    end
    return {r[31:0], 1'b0};
  endfunction

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_st
    logic [31:0] rem_in;
    logic [31:0] n_in;
    logic [31:0] den_in;
    logic [31:0] quo_in;
    logic [32:0] s1;
    logic [32:0] s2;

    if (k == 0) begin : g_head
      assign rem_in = num_i[63:32];
      assign n_in   = num_i[31:0];
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_body
      assign rem_in = rem_q[k-1];
      assign n_in   = n_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign s1 = div_step(rem_in, den_in, n_in[31]);
    assign s2 = div_step(s1[32:1], den_in, n_in[30]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k] <= {quo_in[29:0], s1[0], s2[0]};
      end
    end

    if (k < LAST) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= s2[32:1];
          n_q[k]   <= {n_in[29:0], 2'b00};
          den_q[k] <= den_in;
        end
      end
    end
  end

  assign quo_o = quo_q[LAST];

endmodule

@@ src/prioritized_magnitude_budget.sv @@
// Top level of the prioritised magnitude budget pipeline.
//
// Each input word carries one force source's 3-vector for one particle, with
// tuser flagging the first source of a pass and whether the source is active.
// The block grants the vector whole, scales it to the particle's remaining
// budget, or refuses it, and returns the granted vector with the particle's
// running totals on the master stream. The budget is set over the APB port.
//
// Throughput is one word per cycle while the receiver does not stall and the
// clearing sweep is done. Three stages form the squared length, sixteen the
// square root, one updates the per-particle used magnitude, one multiplies,
// sixteen divide and the last updates the running sums and fills the output
// register. Back-to-back words for the same particle are handled by
// forwarding around the two state memories.
//
// After reset the state memories are cleared, one entry a cycle, from entry
// 0 up to PARTICLES-1; s_axis_tready stays low meanwhile. When the receiver
// stalls, the whole pipeline holds and s_axis_tready falls with it.
module prioritized_magnitude_budget import pmb_pkg::*; #(
  parameter int unsigned PARTICLES = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // Fields from bit 0: particle_index, force_x, force_y, force_z, zero pad.
  input  logic [111:0]         s_axis_tdata,
  // Fields from bit 0: first_source, source_active.
  input  logic [1:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // Fields from bit 0: out_particle, granted_x/y/z, total_x/y/z, zero pad.
  output logic [207:0]         m_axis_tdata,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int unsigned AW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
  localparam int unsigned LA = SQRT_STAGES - 1;
  localparam int unsigned LB = DIV_STAGES - 1;

  logic        en;
  logic        in_fire;
  logic [30:0] max_q;
  logic        clr_q;
  logic [AW-1:0] clr_cnt_q;

  // Configuration register and read-back.
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MAX_MAG_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_MAX_MAGNITUDE)) begin
      max_q <= pwdata[30:0];
    end
  end
  assign prdata = (paddr[2] == REG_MAX_MAGNITUDE) ? {1'b0, max_q} : '0;

  // Clearing sweep over the state memories after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      if (clr_cnt_q == AW'(PARTICLES - 1)) begin
        clr_q <= 1'b0;
      end else begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  // Global advance: the pipeline moves whenever the output register can.
  logic m_valid_q;
  assign en            = !m_valid_q || m_axis_tready;
  assign s_axis_tready = en && !clr_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Unpack the input word.
  pl_t pl_in;
  always_comb begin
    pl_in.first  = s_axis_tuser[0];
    pl_in.active = s_axis_tuser[1];
    pl_in.p      = s_axis_tdata[9:0];
    pl_in.vx     = s_axis_tdata[41:10];
    pl_in.vy     = s_axis_tdata[73:42];
    pl_in.vz     = s_axis_tdata[105:74];
    pl_in.inr    = (32'(s_axis_tdata[9:0]) < 32'(PARTICLES));
  end

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  // Stages one to three: magnitudes, squares and the squared length.
  logic        v1_q, v2_q, v3_q;
  pl_t         pl1_q, pl2_q, pl3_q;
  logic [31:0] ax1_q, ay1_q, az1_q;
  logic [63:0] sqx2_q, sqy2_q, sqz2_q;
  logic [63:0] sum3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pl1_q  <= pl_in;
      ax1_q  <= abs32(pl_in.vx);
      ay1_q  <= abs32(pl_in.vy);
      az1_q  <= abs32(pl_in.vz);
      pl2_q  <= pl1_q;
      sqx2_q <= {32'd0, ax1_q} * {32'd0, ax1_q};
      sqy2_q <= {32'd0, ay1_q} * {32'd0, ay1_q};
      sqz2_q <= {32'd0, az1_q} * {32'd0, az1_q};
      pl3_q  <= pl2_q;
      sum3_q <= sqx2_q + sqy2_q + sqz2_q;
    end
  end

  // Square root, with the word payload delayed alongside.
  logic [31:0] len_a;
  logic        va_q  [SQRT_STAGES];
  pl_t         pla_q [SQRT_STAGES];

  pmb_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .sq_i   (sum3_q),
    .root_o (len_a)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      pla_q[0] <= pl3_q;
      for (int i = 1; i < SQRT_STAGES; i++) begin
        pla_q[i] <= pla_q[i-1];
      end
    end
  end

  // Used-magnitude memory, read one stage ahead of the budget stage.
  logic [30:0]   used_mem [PARTICLES];
  logic [30:0]   rd_used_q;
  logic [AW-1:0] addr_a;
  logic [AW-1:0] raddr_a;
  logic          we_a;
  logic [30:0]   new_used;
  logic          lwa_v_q;
  logic [AW-1:0] lwa_addr_q;
  logic [30:0]   lwa_data_q;

  assign raddr_a = AW'(pla_q[LA-1].p);
  assign addr_a  = AW'(pla_q[LA].p);

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      used_mem[clr_cnt_q] <= '0;
    end else if (we_a) begin
      used_mem[addr_a] <= new_used;
    end
    if (en) begin
      rd_used_q <= used_mem[raddr_a];
    end
  end

  // Budget stage: decide pass, scale or refuse and update the used magnitude.
  logic [30:0] base_used;
  logic [30:0] rem_budget;
  logic        grant_ok;
  logic        scale;
  mode_e       mode_a;

  always_comb begin
    if (pla_q[LA].first) begin
      base_used = '0;
    end else if (lwa_v_q && (lwa_addr_q == addr_a)) begin
      base_used = lwa_data_q;
    end else begin
      base_used = rd_used_q;
    end
    grant_ok   = pla_q[LA].active && pla_q[LA].inr && (base_used < max_q);
    rem_budget = max_q - base_used;
    scale      = len_a > {1'b0, rem_budget};
    if (!grant_ok) begin
      mode_a   = MODE_ZERO;
      new_used = base_used;
    end else if (scale) begin
      mode_a   = MODE_SCALE;
      new_used = max_q;
    end else begin
      mode_a   = MODE_PASS;
      new_used = base_used + len_a[30:0];
    end
  end
  assign we_a = en && va_q[LA] && pla_q[LA].inr;

  logic        vm_q;
  pl_t         plm_q;
  mode_e       modem_q;
  logic [30:0] remm_q;
  logic [31:0] lenm_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      plm_q      <= pla_q[LA];
      modem_q    <= mode_a;
      remm_q     <= rem_budget;
      lenm_q     <= len_a;
      lwa_addr_q <= addr_a;
      lwa_data_q <= new_used;
    end
  end

  // Multiply stage: component magnitude times remaining budget.
  logic        vn_q;
  pl_t         pln_q;
  mode_e       moden_q;
  logic [63:0] prx_q, pry_q, prz_q;
  logic [31:0] lenn_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pln_q   <= plm_q;
      moden_q <= modem_q;
      lenn_q  <= lenm_q;
      prx_q   <= {32'd0, abs32(plm_q.vx)} * {33'd0, remm_q};
      pry_q   <= {32'd0, abs32(plm_q.vy)} * {33'd0, remm_q};
      prz_q   <= {32'd0, abs32(plm_q.vz)} * {33'd0, remm_q};
    end
  end

  // Dividers: scaled magnitude divided by the vector length.
  logic [31:0] qx, qy, qz;
  logic        vb_q    [DIV_STAGES];
  pl_t         plb_q   [DIV_STAGES];
  mode_e       modeb_q [DIV_STAGES];

  pmb_div u_div_x (.clk_i(clk_i), .en_i(en), .num_i(prx_q), .den_i(lenn_q), .quo_o(qx));
  pmb_div u_div_y (.clk_i(clk_i), .en_i(en), .num_i(pry_q), .den_i(lenn_q), .quo_o(qy));
  pmb_div u_div_z (.clk_i(clk_i), .en_i(en), .num_i(prz_q), .den_i(lenn_q), .quo_o(qz));

  always_ff @(posedge clk_i) begin
    if (en) begin
      plb_q[0]   <= pln_q;
      modeb_q[0] <= moden_q;
      for (int i = 1; i < DIV_STAGES; i++) begin
        plb_q[i]   <= plb_q[i-1];
        modeb_q[i] <= modeb_q[i-1];
      end
    end
  end

  // Running-sum memory, read one stage ahead of the sum stage.
  logic [95:0]   sum_mem [PARTICLES];
  logic [95:0]   rd_sum_q;
  logic [AW-1:0] addr_b;
  logic [AW-1:0] raddr_b;
  logic          we_b;
  logic [95:0]   new_sum;
  logic          lwb_v_q;
  logic [AW-1:0] lwb_addr_q;
  logic [95:0]   lwb_data_q;

  assign raddr_b = AW'(plb_q[LB-1].p);
  assign addr_b  = AW'(plb_q[LB].p);

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      sum_mem[clr_cnt_q] <= '0;
    end else if (we_b) begin
      sum_mem[addr_b] <= new_sum;
    end
    if (en) begin
      rd_sum_q <= sum_mem[raddr_b];
    end
  end

  function automatic logic [31:0] grant(input mode_e mode, input logic signed [31:0] v,
                                        input logic [31:0] q);
    logic [31:0] g;
    case (mode)
      MODE_PASS:  g = v;
      MODE_SCALE: g = v[31] ? (32'd0 - q) : q;
      default:    g = '0;
    endcase
    return g;
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    return s[31:0];
  endfunction

  // Sum stage: form the granted vector and the saturated running totals.
  logic [31:0] gx, gy, gz;
  logic [95:0] base_sum;

  always_comb begin
    gx = grant(modeb_q[LB], plb_q[LB].vx, qx);
    gy = grant(modeb_q[LB], plb_q[LB].vy, qy);
    gz = grant(modeb_q[LB], plb_q[LB].vz, qz);
    if (plb_q[LB].first) begin
      base_sum = '0;
    end else if (lwb_v_q && (lwb_addr_q == addr_b)) begin
      base_sum = lwb_data_q;
    end else begin
      base_sum = rd_sum_q;
    end
    new_sum = {sat_add(base_sum[95:64], gz), sat_add(base_sum[63:32], gy),
               sat_add(base_sum[31:0], gx)};
  end
  assign we_b = en && vb_q[LB] && plb_q[LB].inr;

  logic [9:0]  out_p_q;
  logic [31:0] out_gx_q, out_gy_q, out_gz_q;
  logic [95:0] out_tot_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      lwb_addr_q <= addr_b;
      lwb_data_q <= new_sum;
      out_p_q    <= plb_q[LB].p;
      out_gx_q   <= gx;
      out_gy_q   <= gy;
      out_gz_q   <= gz;
      out_tot_q  <= plb_q[LB].inr ? new_sum : '0;
    end
  end

  // Valid bits of every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      vm_q      <= 1'b0;
      vn_q      <= 1'b0;
      lwa_v_q   <= 1'b0;
      lwb_v_q   <= 1'b0;
      m_valid_q <= 1'b0;
      for (int i = 0; i < SQRT_STAGES; i++) begin
        va_q[i] <= 1'b0;
      end
      for (int i = 0; i < DIV_STAGES; i++) begin
        vb_q[i] <= 1'b0;
      end
    end else if (en) begin
      v1_q      <= in_fire;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      va_q[0]   <= v3_q;
      for (int i = 1; i < SQRT_STAGES; i++) begin
        va_q[i] <= va_q[i-1];
      end
      vm_q      <= va_q[LA];
      lwa_v_q   <= va_q[LA] && pla_q[LA].inr;
      vn_q      <= vm_q;
      vb_q[0]   <= vn_q;
      for (int i = 1; i < DIV_STAGES; i++) begin
        vb_q[i] <= vb_q[i-1];
      end
      lwb_v_q   <= vb_q[LB] && plb_q[LB].inr;
      m_valid_q <= vb_q[LB];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'd0, out_tot_q, out_gz_q, out_gy_q, out_gx_q, out_p_q};

endmodule

@@ src/pmb_checker.sv @@
// Port-level assertions for the prioritised magnitude budget block, with its bind.
module pmb_checker import pmb_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [207:0]       m_axis_tdata,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [PADDR_W-1:0] paddr,
  input logic [31:0]        pwdata,
  input logic [31:0]        prdata
);

  // A result word held back by the receiver stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // A stalled output freezes the whole pipeline, so no word is taken in.
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while output stalled");

  // The clearing sweep keeps the input closed straight after reset.
  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !s_axis_tready)
    else $error("input open before state memories were cleared");

  // A budget write reads back in the following cycle.
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && (paddr[2] == REG_MAX_MAGNITUDE)
    |=> (paddr[2] != REG_MAX_MAGNITUDE) || (prdata == {1'b0, $past(pwdata[30:0])}))
    else $error("budget register read-back mismatch");

endmodule

bind prioritized_magnitude_budget pmb_checker u_pmb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata)
);

@@ tb/sv/tb.sv @@
// Self-checking testbench of the prioritised magnitude budget block.
module tb;
  import pmb_pkg::*;

  localparam int unsigned NPART = 1024;
  localparam int unsigned LIMIT = 20000;
  localparam int unsigned DRAIN = 60;

  // Expected result word, laid out as on m_axis_tdata with the particle lowest.
  typedef struct packed {
    logic signed [31:0] tz;
    logic signed [31:0] ty;
    logic signed [31:0] tx;
    logic signed [31:0] gz;
    logic signed [31:0] gy;
    logic signed [31:0] gx;
    logic [9:0]         p;
  } grant_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [207:0] m_axis_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  prioritized_magnitude_budget dut (.*);

  // Predictor state.
  logic [31:0] budget_q;
  logic [31:0] used_mag [NPART];
  logic signed [31:0] acc_x [NPART];
  logic signed [31:0] acc_y [NPART];
  logic signed [31:0] acc_z [NPART];
  grant_t grants_due [$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  bit timed_out = 1'b0;

  initial forever #5 clk_i = ~clk_i;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic logic [63:0] root64(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] shrink(input logic signed [63:0] v,
                                                input logic [63:0] num,
                                                input logic [63:0] den);
    logic [63:0] q;
    q = ((v < 0) ? -v : v) * num / den;
    return (v < 0) ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [31:0] clamp_add(input logic signed [31:0] a,
                                                   input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[31:0];
  endfunction

  // Work out the grant and totals for one accepted word.
  function automatic grant_t grant_word(input logic first, input logic act, input logic [9:0] p,
                                        input logic signed [31:0] x, input logic signed [31:0] y,
                                        input logic signed [31:0] z);
    grant_t g;
    logic signed [63:0] vx, vy, vz, gx, gy, gz;
    logic [63:0] ax, ay, az, len, rem;
    vx = x; vy = y; vz = z;
    gx = 0; gy = 0; gz = 0;
    g = '0;
    g.p = p;
    if (first) begin
      used_mag[p] = 0; acc_x[p] = 0; acc_y[p] = 0; acc_z[p] = 0;
    end
    if (act && used_mag[p] < budget_q) begin
      rem = budget_q - used_mag[p];
      ax = (vx < 0) ? -vx : vx;
      ay = (vy < 0) ? -vy : vy;
      az = (vz < 0) ? -vz : vz;
      len = root64(ax * ax + ay * ay + az * az);
      if (len > rem) begin
        gx = shrink(vx, rem, len);
        gy = shrink(vy, rem, len);
        gz = shrink(vz, rem, len);
        used_mag[p] = budget_q;
      end else begin
        gx = vx; gy = vy; gz = vz;
        used_mag[p] = used_mag[p] + len[31:0];
      end
      acc_x[p] = clamp_add(acc_x[p], gx);
      acc_y[p] = clamp_add(acc_y[p], gy);
      acc_z[p] = clamp_add(acc_z[p], gz);
    end
    g.gx = gx[31:0]; g.gy = gy[31:0]; g.gz = gz[31:0];
    g.tx = acc_x[p]; g.ty = acc_y[p]; g.tz = acc_z[p];
    return g;
  endfunction

  // Send one word after a random gap; with no gap, tvalid stays high straight into it.
  task automatic send_word(input logic first, input logic act, input logic [9:0] p,
                           input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    int unsigned gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, z, y, x, p};
    s_axis_tuser <= {act, first};
    do @(posedge clk_i); while (!(s_axis_tready === 1'b1));
    grants_due.push_back(grant_word(first, act, p, x, y, z));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (grants_due.size() != 0 && !timed_out) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  // Register write in setup and access cycles; the block is idle here.
  task automatic write_budget(input logic [30:0] v);
    wait_idle();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= PADDR_W'(REG_MAX_MAGNITUDE) << 2;
    pwdata <= {1'b0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    budget_q = {1'b0, v};
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rnd_force();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
      3: return $urandom_range(0, 32'h0000_4000) - 32'h0000_2000;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    send_word(1, 1, 10'd0, 32'h0000_8000, 32'd0, 32'd0);
    send_word(0, 1, 10'd0, 32'h0000_4000, 32'd0, 32'd0);
    send_word(0, 1, 10'd0, 32'h0001_0000, 32'h0001_0000, 32'hffff_0000);
    send_word(0, 1, 10'd0, 32'h0001_0000, 32'd0, 32'd0);
    send_word(0, 0, 10'd0, 32'h0001_0000, 32'd0, 32'd0);
    send_word(1, 0, 10'd0, 32'h0001_0000, 32'd0, 32'd0);
    send_word(1, 1, 10'd1023, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_word(0, 1, 10'd1023, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_word(0, 1, 10'd5, 32'hffff_ffff, 32'd1, 32'd0);
    send_word(1, 1, 10'd6, 32'd0, 32'd0, 32'd0);
    send_word(0, 1, 10'd6, 32'hffff_8000, 32'h0000_8000, 32'h0000_2000);
  endtask

  // Largest budget, with large forces of both signs on particles 7 and 8.
  task automatic test_saturation();
    int i;
    write_budget(31'h7fff_ffff);
    send_word(1, 1, 10'd7, 32'h4000_0000, 32'hc000_0000, 32'd0);
    for (i = 0; i < 4; i++)
      send_word(0, 1, 10'd7, 32'h3000_0000, 32'hd000_0000, 32'h0000_0001);
    send_word(1, 1, 10'd8, 32'd0, 32'd0, 32'h2000_0000);
    send_word(0, 1, 10'd8, 32'd0, 32'd0, 32'h2000_0000);
  endtask

  // Passes mostly over particles 0 to 7: a word mostly flagged first source, then up to five more.
  task automatic test_random(input int unsigned words);
    int unsigned n;
    int unsigned k;
    logic [9:0] p;
    n = 0;
    while (n < words) begin
      p = ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, 7));
      if ($urandom_range(0, 9) == 0) p = 10'd1023;
      send_word($urandom_range(0, 9) != 0, $urandom_range(0, 7) != 0, p,
                rnd_force(), rnd_force(), rnd_force());
      n++;
      for (k = $urandom_range(0, 5); k > 0 && n < words; k--) begin
        send_word($urandom_range(0, 15) == 0, $urandom_range(0, 5) != 0, p,
                  rnd_force(), rnd_force(), rnd_force());
        n++;
      end
    end
  endtask

  // Check each result against the oldest expectation.
  always @(posedge clk_i) begin
    grant_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[201:0];
      if (grants_due.size() == 0) begin
        $display("result with nothing expected");
        errors++;
      end else begin
        want = grants_due.pop_front();
        if (got.p !== want.p) report("out_particle", 32'(got.p), 32'(want.p));
        if (got.gx !== want.gx) report("granted_x", got.gx, want.gx);
        if (got.gy !== want.gy) report("granted_y", got.gy, want.gy);
        if (got.gz !== want.gz) report("granted_z", got.gz, want.gz);
        if (got.tx !== want.tx) report("total_x", got.tx, want.tx);
        if (got.ty !== want.ty) report("total_y", got.ty, want.ty);
        if (got.tz !== want.tz) report("total_z", got.tz, want.tz);
      end
    end
  end

  // Receiver stalls at random, with stretches of none.
  initial begin
    int unsigned w;
    forever begin
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      if ($urandom_range(0, 2) == 0) begin
        w = $urandom_range(0, 16);
        if (w != 0) begin
          m_axis_tready <= 1'b0;
          repeat (w) @(posedge clk_i);
        end
      end
    end
  end

  // Watchdog on cycles with work pending but no word moved on either stream and no APB select.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      idle_cycles <= 0;
    else if (s_axis_tvalid || grants_due.size() != 0)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= LIMIT) begin
      timed_out = 1'b1;
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int i;
    budget_q = {1'b0, MAX_MAG_RESET};
    for (i = 0; i < NPART; i++) begin
      used_mag[i] = 0; acc_x[i] = 0; acc_y[i] = 0; acc_z[i] = 0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    write_budget(31'd0);
    send_word(1, 1, 10'd2, 32'h0001_0000, 32'd0, 32'd0);
    test_saturation();
    write_budget(31'h0003_0000);
    test_random(400);
    // Hold off until every expected word has come back.
    wait_idle();
    test_random(100);
    write_budget(31'h0000_0001);
    test_random(150);
    write_budget(31'($urandom));
    test_random(150);
    wait_idle();
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
